>>> rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants for the block pool allocator
// Request and response words, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF  = 256;
  localparam int ALIGN_BYTES_DEF = 8;

  localparam int POOL_HDR    = 24;
  localparam int BLK_HDR     = 8;
  localparam int OFFSET_BASE = POOL_HDR + BLK_HDR;

  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int OFFSET_W   = 20;
  localparam int COUNT_W    = 9;
  localparam int BYTES_W    = 13;
  localparam int TALLY_W    = 9;
  localparam int TALLY_MAX  = 511;
  localparam int STRIDE_W   = 14;

  localparam int COUNT_RESET = 256;
  localparam int BYTES_RESET = 64;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 13;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_COUNT = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_COUNT = 4'd0,
    REG_BLOCK_BYTES = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [OFFSET_W-1:0] granted_offset;
    logic [TALLY_W-1:0]  free_blocks;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: equal-size block pool with a LIFO free list
// Request channel req_valid/req_ready/req carries mode and block_index.
// Response channel rsp_valid/rsp_ready/rsp returns one word per request:
// status, granted index and payload offset, and the free block count.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes block_count
// (index 0) and block_bytes (index 1); write only while no request is open.
// Free and count requests, and an alloc that finds the list empty, have
// their response queued at the accepting edge. An alloc that finds a free
// block reads the head's link from the link memory, and the next request
// waits for that read to set the new head.
// After reset and after each block_count write, the link memory is chained
// by a sweep of one entry per cycle, during which req_ready stays low. A
// block_bytes write holds req_ready low while the block stride is recomputed.
// A two-word response buffer lets requests be taken while a response waits;
// when it is full, req_ready drops until rsp_ready takes a word.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS  = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_BYTES = fbpa_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire fbpa_pkg::req_t                   req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output fbpa_pkg::rsp_t                        rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LW-1:0] END_MARK = LW'(MAX_BLOCKS);
  localparam int RESET_EFF =
    (fbpa_pkg::COUNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : fbpa_pkg::COUNT_RESET;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [fbpa_pkg::COUNT_W-1:0]     block_count;
  logic [fbpa_pkg::BYTES_W-1:0]     block_bytes;
  logic [LW-1:0]                    head;
  logic [LW-1:0]                    head_next;
  logic [fbpa_pkg::TALLY_W-1:0]     tally;
  logic [fbpa_pkg::TALLY_W-1:0]     tally_next;
  logic [fbpa_pkg::TALLY_W-1:0]     tally_inc;
  logic [fbpa_pkg::TALLY_W-1:0]     tally_dec;
  logic [LW-1:0]                    eff_count;
  logic [LW-1:0]                    cfg_eff;
  logic [fbpa_pkg::COUNT_W-1:0]     cfg_count;
  logic                             count_wr;
  logic                             bytes_wr;
  logic                             acc;
  logic                             is_alloc;
  logic                             is_free;
  logic                             head_end;
  logic                             free_bad;
  logic                             mem_we;
  logic                             mem_re;
  logic [LW-1:0]                    mem_rdata;
  logic                             store_busy;
  logic                             offset_busy;
  logic [fbpa_pkg::OFFSET_W-1:0]    offset;
  logic                             push;
  fbpa_pkg::rsp_t                   rsp_d;
  logic                             q_room;

  // config
  assign cfg_ready = 1'b1;
  assign count_wr  = cfg_valid && (cfg_index == fbpa_pkg::REG_BLOCK_COUNT);
  assign bytes_wr  = cfg_valid && (cfg_index == fbpa_pkg::REG_BLOCK_BYTES);
  assign cfg_count = cfg_data[fbpa_pkg::COUNT_W-1:0];

  assign eff_count = (32'(block_count) > MAX_BLOCKS) ? END_MARK : LW'(block_count);
  assign cfg_eff   = (32'(cfg_count) > MAX_BLOCKS) ? END_MARK : LW'(cfg_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= fbpa_pkg::COUNT_W'(fbpa_pkg::COUNT_RESET);
      block_bytes <= fbpa_pkg::BYTES_W'(fbpa_pkg::BYTES_RESET);
    end else begin
      if (count_wr) begin
        block_count <= cfg_count;
      end
      if (bytes_wr) begin
        block_bytes <= cfg_data[fbpa_pkg::BYTES_W-1:0];
      end
    end
  end

  // request decode
  assign req_ready = (state == ST_IDLE) && !store_busy && !offset_busy && q_room;
  assign acc       = req_valid && req_ready;
  assign is_alloc  = (req.mode == fbpa_pkg::MODE_ALLOC);
  assign is_free   = (req.mode == fbpa_pkg::MODE_FREE);
  assign head_end  = (32'(head) >= MAX_BLOCKS);
  assign free_bad  = (32'(req.block_index) >= 32'(eff_count));

  assign tally_inc = (32'(tally) == fbpa_pkg::TALLY_MAX) ? tally
                                                        : tally + fbpa_pkg::TALLY_W'(1);
  assign tally_dec = (tally != '0) ? tally - fbpa_pkg::TALLY_W'(1) : tally;

  assign mem_re = acc && is_alloc && !head_end;
  assign mem_we = acc && is_free && !free_bad;

  always_comb begin
    state_next = state;
    head_next  = head;
    tally_next = tally;
    push       = 1'b0;
    rsp_d      = '0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (is_alloc) begin
            if (head_end) begin
              push              = 1'b1;
              rsp_d.status      = fbpa_pkg::STATUS_EMPTY;
              rsp_d.free_blocks = tally;
            end else begin
              state_next = ST_LOOKUP;
            end
          end else if (is_free) begin
            push = 1'b1;
            if (free_bad) begin
              rsp_d.status      = fbpa_pkg::STATUS_BAD_INDEX;
              rsp_d.free_blocks = tally;
            end else begin
              head_next         = LW'(req.block_index);
              tally_next        = tally_inc;
              rsp_d.status      = fbpa_pkg::STATUS_OK;
              rsp_d.free_blocks = tally_inc;
            end
          end else begin
            push              = 1'b1;
            rsp_d.status      = fbpa_pkg::STATUS_OK;
            rsp_d.free_blocks = tally;
          end
        end
      end
      ST_LOOKUP: begin
        push                 = 1'b1;
        rsp_d.status         = fbpa_pkg::STATUS_OK;
        rsp_d.granted_index  = fbpa_pkg::INDEX_W'(head);
        rsp_d.granted_offset = offset;
        rsp_d.free_blocks    = tally_dec;
        head_next            = mem_rdata;
        tally_next           = tally_dec;
        state_next           = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tally <= fbpa_pkg::TALLY_W'(RESET_EFF);
    end else if (count_wr) begin
      state <= ST_IDLE;
      head  <= (cfg_eff != '0) ? '0 : END_MARK;
      tally <= fbpa_pkg::TALLY_W'(cfg_eff);
    end else begin
      state <= state_next;
      head  <= head_next;
      tally <= tally_next;
    end
  end

  fbpa_link_store #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW),
    .LW    (LW)
  ) u_link_store (
    .clk     (clk),
    .rst     (rst),
    .restart (count_wr),
    .count   (eff_count),
    .we      (mem_we),
    .waddr   (AW'(req.block_index)),
    .wdata   (head),
    .re      (mem_re),
    .raddr   (head[AW-1:0]),
    .rdata   (mem_rdata),
    .busy    (store_busy)
  );

  fbpa_offset #(
    .ALIGN_BYTES (ALIGN_BYTES),
    .IDX_W       (LW)
  ) u_offset (
    .clk         (clk),
    .rst         (rst),
    .bytes_we    (bytes_wr),
    .block_bytes (block_bytes),
    .index       (head),
    .offset      (offset),
    .busy        (offset_busy)
  );

  fbpa_rsp_queue u_rsp_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (rsp_d),
    .valid (rsp_valid),
    .ready (rsp_ready),
    .dout  (rsp),
    .room  (q_room)
  );

  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=> (state == ST_IDLE))
    else $error("alloc lookup held longer than one cycle");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_room || (rsp_valid && rsp_ready)))
    else $error("response pushed into full buffer");

  a_no_write_in_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> !mem_we)
    else $error("link write while a lookup is open");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) <= MAX_BLOCKS)
    else $error("list head beyond end marker");

  a_no_req_in_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(store_busy) |-> !acc)
    else $error("request taken while link sweep starts");

endmodule

`default_nettype wire

>>> rtl/core/fbpa_link_store.sv
// ----------------------------------------------------------------------------
// fbpa_link_store: free list link memory
// Single write, single read port, registered read data. Runs the chaining
// sweep after reset and on every restart, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_link_store #(
  parameter int DEPTH = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          restart,
  input  wire logic [LW-1:0] count,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [LW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [LW-1:0] rdata,
  output logic               busy
);

  localparam logic [LW-1:0] END_MARK = LW'(DEPTH);

  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] sweep_idx;
  logic [LW:0]   sweep_inc;
  logic          sweep_we;
  logic [LW-1:0] sweep_link;

  assign sweep_inc  = {1'b0, sweep_idx} + (LW+1)'(1);
  assign sweep_we   = busy && (sweep_idx < count);
  assign sweep_link = (sweep_inc < {1'b0, count}) ? sweep_inc[LW-1:0] : END_MARK;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy      <= 1'b1;
      sweep_idx <= '0;
    end else if (busy) begin
      sweep_idx <= sweep_inc[LW-1:0];
      if (sweep_inc >= {1'b0, count}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_we) begin
      mem[sweep_idx[AW-1:0]] <= sweep_link;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fbpa_offset.sv
// ----------------------------------------------------------------------------
// fbpa_offset: block stride and payload offset
// Pads the block size to the alignment in two registered steps, then gives
// pool header plus index times stride plus block header.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_offset #(
  parameter int ALIGN_BYTES = fbpa_pkg::ALIGN_BYTES_DEF,
  parameter int IDX_W       = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          bytes_we,
  input  wire logic [fbpa_pkg::BYTES_W-1:0]  block_bytes,
  input  wire logic [IDX_W-1:0]              index,
  output logic      [fbpa_pkg::OFFSET_W-1:0] offset,
  output logic                               busy
);

  localparam int NUM_W   = fbpa_pkg::STRIDE_W;
  localparam int RECIP_S = 16;
  localparam int RECIP_W = RECIP_S + 1;
  localparam int RECIP   = (1 << RECIP_S) / ALIGN_BYTES;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int MUL_W   = IDX_W + fbpa_pkg::STRIDE_W;
  localparam int SUM_W   = MUL_W + fbpa_pkg::OFFSET_W;

  logic [NUM_W-1:0]              num;
  logic [PROD_W-1:0]             prod;
  logic [NUM_W-1:0]              q_est;
  logic [NUM_W-1:0]              num_q;
  logic [NUM_W-1:0]              base;
  logic [NUM_W-1:0]              rem;
  logic [NUM_W-1:0]              padded;
  logic [fbpa_pkg::STRIDE_W-1:0] stride;
  logic [1:0]                    settle;
  logic [MUL_W-1:0]              mul;
  logic [SUM_W-1:0]              sum;

  // round up by reciprocal, then one correction step
  assign num    = NUM_W'(block_bytes) + NUM_W'(ALIGN_BYTES - 1);
  assign prod   = PROD_W'(num) * PROD_W'(RECIP);
  assign base   = q_est * NUM_W'(ALIGN_BYTES);
  assign rem    = num_q - base;
  assign padded = (rem >= NUM_W'(ALIGN_BYTES)) ? base + NUM_W'(ALIGN_BYTES) : base;

  always_ff @(posedge clk) begin
    q_est  <= prod[RECIP_S +: NUM_W];
    num_q  <= num;
    stride <= padded + NUM_W'(fbpa_pkg::BLK_HDR);
  end

  always_ff @(posedge clk) begin
    if (rst || bytes_we) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy   = (settle != 2'd0);
  assign mul    = MUL_W'(index) * MUL_W'(stride);
  assign sum    = SUM_W'(mul) + SUM_W'(fbpa_pkg::OFFSET_BASE);
  assign offset = sum[fbpa_pkg::OFFSET_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/fbpa_rsp_queue.sv
// ----------------------------------------------------------------------------
// fbpa_rsp_queue: two-entry response buffer
// Holds finished response words so that a new request can be taken while
// an earlier response still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_rsp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fbpa_pkg::rsp_t din,
  output logic                valid,
  input  wire logic           ready,
  output fbpa_pkg::rsp_t      dout,
  output logic                room
);

  fbpa_pkg::rsp_t slot0;
  fbpa_pkg::rsp_t slot1;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           pop;

  assign pop   = valid && ready;
  assign valid = (count != 2'd0);
  assign room  = (count != 2'd2);
  assign dout  = slot0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          slot0 <= din;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0 <= din;
        end else if (push) begin
          slot1 <= din;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0 <= slot1;
          if (push) begin
            slot1 <= din;
          end
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> verif/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench for the block pool
// Drives alloc, free and count words with random gaps and response stalls,
// predicts every response from a local copy of the free list, link store
// and free tally, and rewrites block_count and block_bytes between phases.
// ----------------------------------------------------------------------------

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int                     END_MARK   = MAX_BLOCKS_DEF;
  localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 4'd9;

  typedef struct packed {
    logic [COUNT_W-1:0]                     head;
    logic [MAX_BLOCKS_DEF-1:0][COUNT_W-1:0] links;
    logic [TALLY_W-1:0]                     tally;
    logic [COUNT_W-1:0]                     count;
    logic [BYTES_W-1:0]                     bytes;
  } pool_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pool_state_t gen_pool;
  pool_state_t live_pool;
  req_t        pending_reqs[$];
  rsp_t        rsp_due[$];
  logic [7:0]  held[$];
  int          err_count = 0;
  int          cyc = 0;
  logic        quiet;

  fixed_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;
  assign quiet = (cyc >= 1500) && (cyc < 3000);

  function automatic int unsigned eff_blocks(input logic [COUNT_W-1:0] count);
    return (count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : count;
  endfunction

  function automatic logic [OFFSET_W-1:0] blk_offset(input logic [BYTES_W-1:0] bytes,
                                                     input logic [7:0] idx);
    int unsigned padded;
    int unsigned off;
    padded = ((bytes + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF) * ALIGN_BYTES_DEF;
    off = POOL_HDR + idx * (padded + BLK_HDR) + BLK_HDR;
    return off[OFFSET_W-1:0];
  endfunction

  function automatic void pool_rebuild(inout pool_state_t p);
    int unsigned n;
    n = eff_blocks(p.count);
    for (int i = 0; i < MAX_BLOCKS_DEF; i++)
      p.links[i] = (i + 1 < n) ? COUNT_W'(i + 1) : COUNT_W'(END_MARK);
    p.head  = (n != 0) ? '0 : COUNT_W'(END_MARK);
    p.tally = TALLY_W'(n);
  endfunction

  function automatic void pool_write(inout pool_state_t p, input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_BLOCK_COUNT) begin
      p.count = val[COUNT_W-1:0];
      pool_rebuild(p);
    end else if (idx == REG_BLOCK_BYTES) begin
      p.bytes = val[BYTES_W-1:0];
    end
  endfunction

  function automatic void pool_step(inout pool_state_t p, input req_t r, output rsp_t o);
    o = '0;
    o.status = STATUS_OK;
    case (r.mode)
      MODE_ALLOC: begin
        if (p.head >= END_MARK) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.granted_index  = p.head[7:0];
          o.granted_offset = blk_offset(p.bytes, p.head[7:0]);
          p.head = p.links[p.head[7:0]];
          if (p.tally != 0) p.tally = p.tally - TALLY_W'(1);
        end
      end
      MODE_FREE: begin
        if (r.block_index >= eff_blocks(p.count)) begin
          o.status = STATUS_BAD_INDEX;
        end else begin
          p.links[r.block_index] = p.head;
          p.head = {1'b0, r.block_index};
          if (p.tally != TALLY_MAX) p.tally = p.tally + TALLY_W'(1);
        end
      end
      default: ;
    endcase
    o.free_blocks = p.tally;
  endfunction

  task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                             input logic [OFFSET_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    rsp_t o;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        pool_step(live_pool, req, o);
        rsp_due.push_back(o);
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 13)) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          $display("%0t: unexpected word expected none got %0h", $time, rsp);
          err_count++;
        end else begin
          want = rsp_due.pop_front();
          check_field("status", OFFSET_W'(want.status), OFFSET_W'(rsp.status));
          check_field("granted_index", OFFSET_W'(want.granted_index),
                      OFFSET_W'(rsp.granted_index));
          check_field("granted_offset", want.granted_offset, rsp.granted_offset);
          check_field("free_blocks", OFFSET_W'(want.free_blocks),
                      OFFSET_W'(rsp.free_blocks));
        end
      end
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 13);
    end
  end

  task automatic issue(input logic [MODE_W-1:0] mode, input logic [7:0] idx);
    req_t r;
    rsp_t o;
    r.mode = mode;
    r.block_index = idx;
    pool_step(gen_pool, r, o);
    if (mode == MODE_ALLOC && o.status == STATUS_OK) held.push_back(o.granted_index);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || rsp_due.size() != 0);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_write(live_pool, idx, val);
    pool_write(gen_pool, idx, val);
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    int unsigned pct;
    int unsigned r;
    int unsigned j;
    int unsigned eff;
    logic [7:0] idx;
    held.delete();
    for (int k = 0; k < n; k++) begin
      if (k % 16 == 0) pct = $urandom_range(20, 70);
      eff = eff_blocks(gen_pool.count);
      if ($urandom_range(0, 99) < pct) begin
        issue(MODE_ALLOC, 8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          if (held.size() > 0) begin
            j = $urandom_range(0, held.size() - 1);
            idx = held[j];
            held.delete(j);
          end else if (eff != 0) begin
            idx = 8'($urandom_range(0, eff - 1));
          end else begin
            idx = 8'($urandom);
          end
          issue(MODE_FREE, idx);
        end else if (r < 86) begin
          issue(MODE_FREE, 8'($urandom));
        end else if (r < 94) begin
          issue(MODE_COUNT, 8'($urandom));
        end else begin
          issue(MODE_SPARE, 8'($urandom));
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    gen_pool = '0;
    gen_pool.count = COUNT_RESET;
    gen_pool.bytes = BYTES_RESET;
    pool_rebuild(gen_pool);
    live_pool = gen_pool;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings
    issue(MODE_ALLOC, 8'h00);
    issue(MODE_ALLOC, 8'hff);
    issue(MODE_COUNT, 8'h00);
    issue(MODE_SPARE, 8'hff);
    issue(MODE_FREE, 8'hff);
    issue(MODE_FREE, 8'h01);
    issue(MODE_ALLOC, 8'h00);
    issue(MODE_FREE, 8'h00);
    wait_idle();

    // single block, double free loops the list, tally floor
    set_reg(REG_BLOCK_BYTES, 13'd1);
    set_reg(REG_SPARE, 13'h1fff);
    set_reg(REG_BLOCK_COUNT, 13'd1);
    issue(MODE_ALLOC, 8'h00);
    issue(MODE_ALLOC, 8'h00);
    issue(MODE_FREE, 8'h01);
    issue(MODE_FREE, 8'h00);
    issue(MODE_FREE, 8'h00);
    repeat (4) issue(MODE_ALLOC, 8'h00);
    issue(MODE_COUNT, 8'h00);
    wait_idle();

    // empty pool
    set_reg(REG_BLOCK_COUNT, 13'd0);
    issue(MODE_ALLOC, 8'h00);
    issue(MODE_FREE, 8'h00);
    issue(MODE_COUNT, 8'h00);
    wait_idle();

    // clamped count and offset wrap
    set_reg(REG_BLOCK_COUNT, 13'd511);
    set_reg(REG_BLOCK_BYTES, 13'h1fff);
    issue(MODE_FREE, 8'd200);
    issue(MODE_ALLOC, 8'h00);
    issue(MODE_FREE, 8'hff);
    issue(MODE_ALLOC, 8'h00);
    wait_idle();

    set_reg(REG_BLOCK_COUNT, 13'd6);
    set_reg(REG_BLOCK_BYTES, 13'd4096);
    random_phase(70);
    set_reg(REG_BLOCK_BYTES, 13'd0);
    set_reg(REG_BLOCK_COUNT, 13'd256);
    random_phase(70);
    set_reg(REG_BLOCK_BYTES, 13'h1fff);
    set_reg(REG_BLOCK_COUNT, 13'd1);
    random_phase(70);
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_BLOCK_BYTES, 13'($urandom_range(1, 4096)));
      set_reg(REG_BLOCK_COUNT, ($urandom_range(0, 1) == 1) ? 13'($urandom_range(2, 12))
                                                          : 13'($urandom_range(1, 256)));
      random_phase(70);
    end

    // tally saturation through repeated frees
    set_reg(REG_BLOCK_COUNT, 13'd256);
    repeat (270) issue(MODE_FREE, 8'($urandom));
    repeat (20) issue(MODE_ALLOC, 8'($urandom));
    issue(MODE_COUNT, 8'h00);
    wait_idle();

    repeat (20) @(posedge clk);
    if (err_count == 0 && rsp_due.size() == 0) begin
      $display("tb_fixed_block_pool_allocator: clean");
    end else begin
      $display("tb_fixed_block_pool_allocator: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_fixed_block_pool_allocator: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_link_store.sv
rtl/core/fbpa_offset.sv
rtl/core/fbpa_rsp_queue.sv
rtl/core/fixed_block_pool_allocator.sv
verif/tb_fixed_block_pool_allocator.sv
